// File: hdl/cbr_pkg.sv
// ----------------------------------------------------------------------------
// cbr_pkg: shared types and constants of the clock divider ratio finder
// Field widths, result status codes, register addresses and the command and
// status groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cbr_pkg;

  // Fixed field widths.
  localparam int unsigned TgtW = 32;
  localparam int unsigned SysW = 31;
  localparam int unsigned OutW = 16;

  // Configuration port.
  localparam int unsigned PAddrW = 2;
  localparam int unsigned PDataW = 32;
  localparam logic [PAddrW-1:0] AddrSysClk = 2'd0;

  // Result status codes.
  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StNeg   = 2'd1,
    StAbove = 2'd2,
    StBelow = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the accepted item
    logic pre;     // range checks and walk set-up
    logic walk;    // best-candidate update and mediant step
    logic mul;     // denominator limit test and distance products
    logic out_ld;  // move the finished result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic stop;    // the current phase has settled the result
  } dp_stat_t;

endpackage

`default_nettype wire

// File: hdl/cbr_if.sv
// ----------------------------------------------------------------------------
// cbr_if: item channels of the clock divider ratio finder
// A request channel carrying the target frequency and a result channel
// carrying status and ratio, both with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbr_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [cbr_pkg::TgtW-1:0]     req_hz;

  modport source (output valid, output req_hz, input ready);
  modport sink   (input valid, input req_hz, output ready);
endinterface

interface cbr_out_if;
  logic                                valid;
  logic                                ready;
  cbr_pkg::status_e                    status;
  logic [cbr_pkg::OutW-1:0]            numerator;
  logic [cbr_pkg::OutW-1:0]            denominator;

  modport source (output valid, output status, output numerator, output denominator,
                  input ready);
  modport sink   (input valid, input status, input numerator, input denominator,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/cbr_ctrl.sv
// ----------------------------------------------------------------------------
// cbr_ctrl: sequencing controller of the ratio finder
// Accepts one item at a time, steps the datapath through range checks and
// the mediant walk, and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cbr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  cbr_pkg::dp_stat_t   stat_i,
  output cbr_pkg::ctrl_cmd_t  cmd_o
);
  import cbr_pkg::*;

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SPre  = 3'd1;
  localparam logic [2:0] SWalk = 3'd2;
  localparam logic [2:0] SMul  = 3'd3;
  localparam logic [2:0] SFin  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // Next state, commands and output valid.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = SPre;
        end
      end
      SPre: begin
        cmd_o.pre = 1'b1;
        state_d   = stat_i.stop ? SFin : SWalk;
      end
      SWalk: begin
        cmd_o.walk = 1'b1;
        state_d    = stat_i.stop ? SFin : SMul;
      end
      SMul: begin
        cmd_o.mul = 1'b1;
        state_d   = stat_i.stop ? SFin : SWalk;
      end
      SFin: begin
        // Wait until the output register is free or being emptied.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_ld = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: hdl/cbr_dp.sv
// ----------------------------------------------------------------------------
// cbr_dp: datapath of the ratio finder
// Holds the Stern-Brocot bracket, the current mediant and the best candidate,
// each with its signed error tgt*den - sys*num kept up to date by addition,
// and compares distances with two registered products per step.
// ----------------------------------------------------------------------------
`default_nettype none

module cbr_dp #(
  parameter int unsigned MAX_DEN = 65535
) (
  input  logic                              clk_i,
  input  cbr_pkg::ctrl_cmd_t                cmd_i,
  output cbr_pkg::dp_stat_t                 stat_o,
  input  logic [cbr_pkg::SysW-1:0]          sys_hz_i,
  input  logic signed [cbr_pkg::TgtW-1:0]   req_hz_i,
  output cbr_pkg::status_e                  status_o,
  output logic [cbr_pkg::OutW-1:0]          numerator_o,
  output logic [cbr_pkg::OutW-1:0]          denominator_o
);
  import cbr_pkg::*;

  localparam int unsigned DenW  = $clog2(MAX_DEN + 1);
  localparam int unsigned CDenW = DenW + 1;            // mediant may reach 2*MAX_DEN
  localparam int unsigned EW    = SysW + DenW + 2;     // signed error width
  localparam int unsigned MagW  = SysW + DenW;         // error magnitude in range
  localparam int unsigned PW    = MagW + DenW;         // distance product width
  localparam int unsigned MinW  = SysW + 1 + DenW;     // minimum-frequency product

  // Captured item.
  logic               neg_q;
  logic [SysW-1:0]    tgt_q;

  // Walk state: left and right bracket, current mediant, best candidate.
  logic [DenW-1:0]    l_n_q, l_d_q, r_n_q, r_d_q, b_n_q, b_d_q;
  logic [CDenW-1:0]   c_n_q, c_d_q;
  logic signed [EW-1:0] e_l_q, e_r_q, e_c_q, e_b_q;
  logic [PW-1:0]      p1_q, p2_q;

  // Result holding and output registers.
  status_e            res_st_q, out_st_q;
  logic [DenW-1:0]    res_n_q, res_d_q;
  logic [OutW-1:0]    out_n_q, out_d_q;

  logic [SysW:0]      tgt_inc;
  logic [MinW-1:0]    min_prod;
  logic               above, below, pre_stop, exact, over, better;
  status_e            pre_st;
  logic signed [EW-1:0] e_sys, e_tgt, abs_c, abs_b;
  logic [MagW-1:0]    mag_c, mag_b;

  // Capture the item on accept.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_q <= req_hz_i[TgtW-1];
      tgt_q <= req_hz_i[SysW-1:0];
    end
  end

  // Range checks; below the minimum means (tgt+1)*MAX_DEN <= sys.
  always_comb begin
    tgt_inc  = {1'b0, tgt_q} + (SysW + 1)'(1);
    min_prod = MinW'(tgt_inc) * MinW'(MAX_DEN);
    above    = tgt_q > sys_hz_i;
    below    = min_prod <= MinW'(sys_hz_i);
    if (neg_q) begin
      pre_st = StNeg;
    end else if (above) begin
      pre_st = StAbove;
    end else if (below) begin
      pre_st = StBelow;
    end else begin
      pre_st = StOk;
    end
    pre_stop = pre_st != StOk;
  end

  // Walk conditions and error magnitudes.
  always_comb begin
    e_sys  = EW'(sys_hz_i);
    e_tgt  = EW'(tgt_q);
    exact  = e_c_q == '0;
    over   = c_d_q > CDenW'(MAX_DEN);
    better = p1_q < p2_q;
    abs_c  = e_c_q[EW-1] ? -e_c_q : e_c_q;
    abs_b  = e_b_q[EW-1] ? -e_b_q : e_b_q;
    mag_c  = abs_c[MagW-1:0];
    mag_b  = abs_b[MagW-1:0];
    stat_o.stop = (cmd_i.pre && pre_stop) || (cmd_i.walk && exact) ||
                  (cmd_i.mul && over);
  end

  // Walk registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.pre) begin
      // Start from left 1/0, right 0/1, current and best 1/1.
      l_n_q <= DenW'(1);
      l_d_q <= '0;
      e_l_q <= -e_sys;
      r_n_q <= '0;
      r_d_q <= DenW'(1);
      e_r_q <= e_tgt;
      c_n_q <= CDenW'(1);
      c_d_q <= CDenW'(1);
      e_c_q <= e_tgt - e_sys;
      b_n_q <= DenW'(1);
      b_d_q <= DenW'(1);
      e_b_q <= e_tgt - e_sys;
      p1_q  <= '0;
      p2_q  <= '0;
    end else if (cmd_i.walk) begin
      // Take the last candidate as best when strictly closer.
      if (better) begin
        b_n_q <= c_n_q[DenW-1:0];
        b_d_q <= c_d_q[DenW-1:0];
        e_b_q <= e_c_q;
      end
      // Step toward the target by one mediant.
      if (!exact) begin
        if (e_c_q[EW-1]) begin
          l_n_q <= c_n_q[DenW-1:0];
          l_d_q <= c_d_q[DenW-1:0];
          e_l_q <= e_c_q;
          c_n_q <= CDenW'(r_n_q) + c_n_q;
          c_d_q <= CDenW'(r_d_q) + c_d_q;
          e_c_q <= e_r_q + e_c_q;
        end else begin
          r_n_q <= c_n_q[DenW-1:0];
          r_d_q <= c_d_q[DenW-1:0];
          e_r_q <= e_c_q;
          c_n_q <= CDenW'(l_n_q) + c_n_q;
          c_d_q <= CDenW'(l_d_q) + c_d_q;
          e_c_q <= e_l_q + e_c_q;
        end
      end
    end else if (cmd_i.mul) begin
      // Distances scale as |e|/den: compare |e_c|*d_b against |e_b|*d_c.
      p1_q <= PW'(mag_c) * PW'(b_d_q);
      p2_q <= PW'(mag_b) * PW'(c_d_q[DenW-1:0]);
    end
  end

  // Result capture when a phase settles the answer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.pre && pre_stop) begin
      res_st_q <= pre_st;
      res_n_q  <= '0;
      res_d_q  <= '0;
    end else if (cmd_i.walk && exact) begin
      res_st_q <= StOk;
      res_n_q  <= c_n_q[DenW-1:0];
      res_d_q  <= c_d_q[DenW-1:0];
    end else if (cmd_i.mul && over) begin
      res_st_q <= StOk;
      res_n_q  <= b_n_q;
      res_d_q  <= b_d_q;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_st_q <= res_st_q;
      out_n_q  <= OutW'(res_n_q);
      out_d_q  <= OutW'(res_d_q);
    end
  end

  assign status_o      = out_st_q;
  assign numerator_o   = out_n_q;
  assign denominator_o = out_d_q;

endmodule

`default_nettype wire

// File: hdl/clock_divider_best_ratio.sv
// ----------------------------------------------------------------------------
// clock_divider_best_ratio: best divider ratio for a requested frequency
//
// Usage: write the system clock in Hz to the register at address 0 of the
// APB port (reset value 125000000). Each item on in_i carries a signed
// target frequency; one result per item leaves on out_o with a status
// (ok, negative, above the system clock, below system/MAX_DEN) and the
// fraction num/den, den <= MAX_DEN, closest to target/system clock.
// One item is worked on at a time. A rejected item ends after the range
// checks; otherwise the Stern-Brocot walk alternates a step state (mediant
// step and best update) with a multiply state (limit test and the two
// distance products), and ends on an exact match in the step state or when
// the denominator limit is passed in the multiply state. The finished result
// then moves to the output register, which raises out_o.valid.
// The next item is accepted as soon as the walk is idle, even while a
// result still waits on out_o. If the receiver stalls, a finished result
// is held until the output register is free. Reset returns the controller
// to idle, empties the output and restores the register.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_divider_best_ratio #(
  parameter int unsigned MAX_DEN = 65535
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  cbr_in_if.sink                           in_i,
  cbr_out_if.source                        out_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cbr_pkg::PAddrW-1:0]       paddr,
  input  logic [cbr_pkg::PDataW-1:0]       pwdata,
  output logic [cbr_pkg::PDataW-1:0]       prdata,
  output logic                             pready
);
  import cbr_pkg::*;

  logic [SysW-1:0] sys_hz_q;
  ctrl_cmd_t       cmd;
  dp_stat_t        stat;

  // System clock register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sys_hz_q <= SysW'(125000000);
    end else if (psel && penable && pwrite && paddr == AddrSysClk) begin
      sys_hz_q <= pwdata[SysW-1:0];
    end
  end

  // Register read-back; no wait states.
  assign pready = 1'b1;
  assign prdata = (paddr == AddrSysClk) ? PDataW'(sys_hz_q) : '0;

  cbr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cbr_dp #(
    .MAX_DEN (MAX_DEN)
  ) u_dp (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .sys_hz_i      (sys_hz_q),
    .req_hz_i      (in_i.req_hz),
    .status_o      (out_o.status),
    .numerator_o   (out_o.numerator),
    .denominator_o (out_o.denominator)
  );

endmodule

`default_nettype wire
